[hdl/tcsp_pkg.sv]
// Shared types, byte codes and defaults for the telnet command stream parser.
package tcsp_pkg;

	localparam int SUB_DEPTH_DEF    = 32;
	localparam int OPTION_SLOTS_DEF = 4;

	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 32;
	localparam int SLOTS_W = 4;

	localparam logic [CFG_IW-1:0] REG_OPTION_CODES = 2'd0;
	localparam logic [CFG_IW-1:0] REG_OPTION_VALID = 2'd1;
	localparam logic [CFG_IW-1:0] REG_LOCAL_WILL   = 2'd2;
	localparam logic [CFG_IW-1:0] REG_LOCAL_DO     = 2'd3;

	localparam logic [7:0] BYTE_SE   = 8'd240;
	localparam logic [7:0] BYTE_SB   = 8'd250;
	localparam logic [7:0] BYTE_WILL = 8'd251;
	localparam logic [7:0] BYTE_WONT = 8'd252;
	localparam logic [7:0] BYTE_DO   = 8'd253;
	localparam logic [7:0] BYTE_DONT = 8'd254;
	localparam logic [7:0] BYTE_IAC  = 8'd255;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_NEGO = 2'd2;
	localparam logic [1:0] KIND_SUB  = 2'd3;

	typedef struct packed {
		logic accept;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic has_beat;
		logic burst_start;
		logic burst_end;
	} stat_t;

endpackage

[hdl/tcsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[hdl/tcsp_ctrl.sv]
// Controller: handshake and burst sequencing for the telnet parser.
module tcsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tcsp_pkg::stat_t     stat,
	output tcsp_pkg::cmd_t      cmd
);
	import tcsp_pkg::*;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EMIT = 1'b1;

	logic [0:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a beat when it is empty or drains now.
	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE) && out_free;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.emit   = (state_q == S_EMIT) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && stat.burst_start) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cmd.emit && stat.burst_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((cmd.accept && stat.has_beat) || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

[hdl/tcsp_datapath.sv]
// Datapath: parse state, option table, suboption store and output register.
module tcsp_datapath #(
	parameter int SUB_DEPTH    = tcsp_pkg::SUB_DEPTH_DEF,
	parameter int OPTION_SLOTS = tcsp_pkg::OPTION_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcsp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [tcsp_pkg::CFG_DW-1:0] cfg_data,
	input  logic [7:0]                  rx_byte,
	input  tcsp_pkg::cmd_t              cmd,
	output tcsp_pkg::stat_t             stat,
	output logic [1:0]                  kind,
	output logic [7:0]                  value,
	output logic [7:0]                  option_number,
	output logic                        remote_will,
	output logic                        remote_do,
	output logic                        last
);
	import tcsp_pkg::*;

	localparam int DEPTH = SUB_DEPTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(SUB_DEPTH + 2);

	localparam logic [LW-1:0] LEN_IDLE    = LW'(0);
	localparam logic [LW-1:0] LEN_IAC     = LW'(1);
	localparam logic [LW-1:0] LEN_VERB    = LW'(2);
	localparam logic [LW-1:0] LEN_SUB     = LW'(3);
	localparam logic [LW-1:0] LEN_OPT_END = LW'(4);
	localparam logic [LW-1:0] LEN_CAP     = LW'(SUB_DEPTH);
	localparam logic [AW-1:0] SUB_FIRST   = AW'(3);

	// Configuration registers.
	logic [31:0]        codes_q;
	logic [SLOTS_W-1:0] valid_q, lwill_q, ldo_q;

	// Parse state.
	logic [LW-1:0]      len_q, len_d;
	logic               esc_q, esc_d;
	logic [SLOTS_W-1:0] rwf_q, rwf_d, rdf_q, rdf_d;
	logic [7:0]         verb_q, verb_d, opt_q, opt_d;
	logic [AW-1:0]      idx_q, end_q;

	// Output register.
	logic [1:0] kind_q;
	logic [7:0] value_q, onum_q;
	logic       rw_q, rd_q, last_q;

	// Option lookup and per-byte results.
	logic [7:0]         key;
	logic               hit;
	logic [1:0]         slot;
	logic [SLOTS_W-1:0] slot_mask;
	logic               beat, burst;
	logic [1:0]         b_kind;
	logic [7:0]         b_value, b_opt;
	logic               b_rw, b_rd;
	logic [LW-1:0]      wptr;
	logic               wr_en;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [7:0]         ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			valid_q <= '0;
			lwill_q <= '0;
			ldo_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPTION_CODES: codes_q <= cfg_data;
				REG_OPTION_VALID: valid_q <= cfg_data[SLOTS_W-1:0];
				REG_LOCAL_WILL:   lwill_q <= cfg_data[SLOTS_W-1:0];
				REG_LOCAL_DO:     ldo_q   <= cfg_data[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	// A negotiation looks up the byte arriving now; a suboption end looks up
	// the stored option byte.
	assign key = (len_q == LEN_VERB) ? rx_byte : opt_q;

	always_comb begin
		hit  = 1'b0;
		slot = 2'd0;
		for (int s = OPTION_SLOTS - 1; s >= 0; s--) begin
			if (valid_q[s] && (codes_q[8*s +: 8] == key)) begin
				hit  = 1'b1;
				slot = 2'(s);
			end
		end
	end

	assign slot_mask = SLOTS_W'(1) << slot;
	assign wptr      = (len_q > LEN_CAP) ? LEN_CAP : len_q;

	always_comb begin
		len_d   = len_q;
		esc_d   = esc_q;
		verb_d  = verb_q;
		opt_d   = opt_q;
		rwf_d   = rwf_q;
		rdf_d   = rdf_q;
		beat    = 1'b0;
		burst   = 1'b0;
		b_kind  = KIND_DATA;
		b_value = rx_byte;
		b_opt   = 8'd0;
		b_rw    = 1'b0;
		b_rd    = 1'b0;
		wr_en   = 1'b0;
		if (len_q == LEN_IDLE) begin
			if (rx_byte == BYTE_IAC) begin
				len_d = LEN_IAC;
				esc_d = 1'b0;
			end else begin
				beat = 1'b1;
			end
		end else if (len_q == LEN_IAC) begin
			if (rx_byte == BYTE_IAC) begin
				len_d = LEN_IDLE;
				beat  = 1'b1;
			end else begin
				verb_d = rx_byte;
				if (rx_byte < BYTE_SB) begin
					beat   = 1'b1;
					b_kind = KIND_CMD;
					len_d  = LEN_IDLE;
				end else begin
					len_d = LEN_VERB;
				end
			end
		end else if (len_q == LEN_VERB) begin
			opt_d = rx_byte;
			if (verb_q != BYTE_SB) begin
				beat   = 1'b1;
				b_kind = KIND_NEGO;
				b_opt  = rx_byte;
				len_d  = LEN_IDLE;
				case (verb_q)
					BYTE_WILL: b_value = (hit && lwill_q[slot]) ? BYTE_DO : BYTE_DONT;
					BYTE_WONT: b_value = BYTE_DONT;
					BYTE_DO:   b_value = (hit && ldo_q[slot]) ? BYTE_WILL : BYTE_WONT;
					default:   b_value = BYTE_WONT;
				endcase
				if (hit) begin
					case (verb_q)
						BYTE_WILL: rwf_d = rwf_q | slot_mask;
						BYTE_WONT: rwf_d = rwf_q & ~slot_mask;
						BYTE_DO:   rdf_d = rdf_q | slot_mask;
						default:   rdf_d = rdf_q & ~slot_mask;
					endcase
					b_rw = rwf_d[slot];
					b_rd = rdf_d[slot];
				end
			end else begin
				len_d = LEN_SUB;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (rx_byte == BYTE_SE) begin
				len_d = LEN_IDLE;
				if (hit) begin
					// The option goes out first; stored bytes follow as a burst.
					beat    = 1'b1;
					b_kind  = KIND_SUB;
					b_value = opt_q;
					burst   = (len_q != LEN_OPT_END);
				end
			end else if (rx_byte != BYTE_IAC) begin
				// Drop the stored IAC together with this byte.
				len_d = len_q - LW'(1);
			end
		end else begin
			wr_en = 1'b1;
			len_d = wptr + LW'(1);
			esc_d = (rx_byte == BYTE_IAC);
		end
	end

	assign stat.has_beat    = beat;
	assign stat.burst_start = burst;
	assign stat.burst_end   = (idx_q == end_q);

	assign ram_re    = (cmd.accept && burst) || (cmd.emit && !stat.burst_end);
	assign ram_raddr = cmd.accept ? SUB_FIRST : idx_q + AW'(1);

	tcsp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept && wr_en),
		.waddr (wptr[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_IDLE;
			esc_q <= 1'b0;
			rwf_q <= '0;
			rdf_q <= '0;
		end else if (cmd.accept) begin
			len_q <= len_d;
			esc_q <= esc_d;
			rwf_q <= rwf_d;
			rdf_q <= rdf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			verb_q <= verb_d;
			opt_q  <= opt_d;
		end
		if (cmd.accept && beat) begin
			kind_q  <= b_kind;
			value_q <= b_value;
			onum_q  <= b_opt;
			rw_q    <= b_rw;
			rd_q    <= b_rd;
			last_q  <= !burst;
		end else if (cmd.emit) begin
			kind_q  <= KIND_SUB;
			value_q <= ram_rdata;
			onum_q  <= 8'd0;
			rw_q    <= 1'b0;
			rd_q    <= 1'b0;
			last_q  <= stat.burst_end;
		end
		if (cmd.accept && burst) begin
			idx_q <= SUB_FIRST;
			end_q <= AW'(len_q - LW'(2));
		end else if (cmd.emit) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign kind          = kind_q;
	assign value         = value_q;
	assign option_number = onum_q;
	assign remote_will   = rw_q;
	assign remote_do     = rd_q;
	assign last          = last_q;
endmodule

[hdl/telnet_command_stream_parser_unit.sv]
// Top level of the telnet command stream parser.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+-------------------------------------------
//   input    | in_valid / in_ready          | rx_byte
//   output   | out_valid / out_ready        | kind, value, option_number, remote_will,
//            |                              | remote_do, last
//   config   | cfg_we (no wait)             | cfg_index, cfg_data
//
// Every received byte is taken when in_ready is high, and its single result beat, if it
// has one, appears in the output register on the next cycle. A suboption end
// (IAC SE) whose option is known starts a burst: the option beat, then one
// stored byte per cycle read from the suboption store while the output is not stalled;
// the burst holds the input off until its last beat enters the output register.
// Reset clears the parse state, the remote flags and the option table; the
// store itself is not cleared. A stalled output beat holds the input off.
module telnet_command_stream_parser_unit #(
	parameter int SUB_DEPTH    = tcsp_pkg::SUB_DEPTH_DEF,
	parameter int OPTION_SLOTS = tcsp_pkg::OPTION_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcsp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [tcsp_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [7:0]                  value,
	output logic [7:0]                  option_number,
	output logic                        remote_will,
	output logic                        remote_do,
	output logic                        last
);
	import tcsp_pkg::*;

	// The controller sees only the handshake and a few status bits; the
	// datapath does all byte decoding, table lookups and store access.
	cmd_t  cmd;
	stat_t stat;

	tcsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcsp_datapath #(
		.SUB_DEPTH    (SUB_DEPTH),
		.OPTION_SLOTS (OPTION_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.value         (value),
		.option_number (option_number),
		.remote_will   (remote_will),
		.remote_do     (remote_do),
		.last          (last)
	);
endmodule

[hdl/tcsp_checker.sv]
// Port-level assertions for the telnet parser, bound to the top level.
module tcsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] value,
	input logic [7:0] option_number,
	input logic       remote_will,
	input logic       remote_do,
	input logic       last
);
	import tcsp_pkg::*;

	// A beat that waits keeps its value, kind and last flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind)
			&& $stable(last))
		else $error("output beat changed while stalled");

	// Only a suboption burst has beats that are not the last of their byte.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_SUB) |-> last)
		else $error("non-suboption beat without last");

	// Option number and flags are carried by negotiation replies only.
	a_nego_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_NEGO) |->
			(option_number == 8'd0) && !remote_will && !remote_do)
		else $error("option fields set on a non-negotiation beat");

	// A stalled output beat keeps the input side closed.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
endmodule

bind telnet_command_stream_parser_unit tcsp_checker u_tcsp_checker (.*);

[dv/testbench.sv]
// Testbench for the telnet command stream parser: directed and random byte streams checked beat by beat.
`timescale 1ns / 100ps

module testbench;
	import tcsp_pkg::*;

	// The predictor uses the same sizes as the default build of the block.
	localparam int SUB_DEPTH     = SUB_DEPTH_DEF;
	localparam int OPTION_SLOTS  = OPTION_SLOTS_DEF;
	// Margin after the last predicted beat has come, before the next test starts.
	localparam int SETTLE_CYCLES = 4;
	// Even with the largest burst after every byte under the longest stalls a run stays
	// below this limit.
	localparam int CYCLE_LIMIT   = 5000000;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] option_number;
		logic       remote_will;
		logic       remote_do;
		logic       last;
	} beat_t;

	// Every input of the block starts at a known value.
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_DW-1:0]   cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [7:0]          rx_byte   = 8'd0;
	logic                out_valid;
	logic                out_ready = 1'b1;
	logic [1:0]          kind;
	logic [7:0]          value;
	logic [7:0]          option_number;
	logic                remote_will;
	logic                remote_do;
	logic                last;

	// Our own copy of the option table and of the parse state of the block.
	logic [31:0]         tbl_codes = '0;
	logic [3:0]          tbl_valid = '0;
	logic [3:0]          tbl_will  = '0;
	logic [3:0]          tbl_do    = '0;
	logic [7:0]          cmd_store [SUB_DEPTH+1];
	int                  parse_len = 0;
	bit                  esc_seen  = 1'b0;
	logic [3:0]          peer_will = '0;
	logic [3:0]          peer_do   = '0;

	beat_t               expected_beats[$];
	int                  mismatches    = 0;
	int                  cycle_count   = 0;
	int                  stall_left    = 0;
	bit                  stall_enable  = 1'b1;

	telnet_command_stream_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.value         (value),
		.option_number (option_number),
		.remote_will   (remote_will),
		.remote_do     (remote_do),
		.last          (last)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// The receiver stalls in bursts of random length while stalls are enabled.
	// A burst that is already running always finishes, even after stalls are turned off.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				out_ready <= 1'b1;
		end else if (stall_enable && $urandom_range(0, 15) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(1, 18);
		end
	end

	// Lowest valid slot whose code equals the option, or -1 when none matches.
	function automatic int slot_lookup(input logic [7:0] opt);
		for (int s = 0; s < OPTION_SLOTS && s < 4; s++)
			if (tbl_valid[s] && tbl_codes[8*s +: 8] == opt)
				return s;
		return -1;
	endfunction

	task automatic push_beat(input logic [1:0] k, input logic [7:0] v, input logic [7:0] opt,
			input logic rw, input logic rd, input logic fin);
		beat_t b;
		b.kind          = k;
		b.value         = v;
		b.option_number = opt;
		b.remote_will   = rw;
		b.remote_do     = rd;
		b.last          = fin;
		expected_beats.push_back(b);
	endtask

	// Advances the parse state by one accepted byte and queues every beat that it causes.
	task automatic parse_rx_byte(input logic [7:0] b);
		int         s;
		int         size;
		logic [7:0] reply;
		if (parse_len == 0) begin
			// Outside any command: data passes, an IAC opens a command.
			if (b == BYTE_IAC) begin
				cmd_store[0] = BYTE_IAC;
				parse_len    = 1;
				esc_seen     = 1'b0;
			end else begin
				push_beat(KIND_DATA, b, 8'd0, 1'b0, 1'b0, 1'b1);
			end
		end else if (parse_len == 1) begin
			if (b == BYTE_IAC) begin
				// A doubled IAC is one data byte 255.
				parse_len = 0;
				push_beat(KIND_DATA, b, 8'd0, 1'b0, 1'b0, 1'b1);
			end else begin
				cmd_store[1] = b;
				parse_len    = 2;
				if (b < BYTE_SB) begin
					push_beat(KIND_CMD, b, 8'd0, 1'b0, 1'b0, 1'b1);
					parse_len = 0;
				end
			end
		end else if (parse_len == 2) begin
			cmd_store[2] = b;
			parse_len    = 3;
			if (cmd_store[1] != BYTE_SB) begin
				// Negotiation: the reply depends on the verb and on the local table bits.
				s = slot_lookup(b);
				case (cmd_store[1])
					BYTE_WILL: reply = (s >= 0 && tbl_will[s]) ? BYTE_DO : BYTE_DONT;
					BYTE_WONT: reply = BYTE_DONT;
					BYTE_DO:   reply = (s >= 0 && tbl_do[s]) ? BYTE_WILL : BYTE_WONT;
					default:   reply = BYTE_WONT;
				endcase
				if (s >= 0) begin
					case (cmd_store[1])
						BYTE_WILL: peer_will[s] = 1'b1;
						BYTE_WONT: peer_will[s] = 1'b0;
						BYTE_DO:   peer_do[s]   = 1'b1;
						default:   peer_do[s]   = 1'b0;
					endcase
					push_beat(KIND_NEGO, reply, b, peer_will[s], peer_do[s], 1'b1);
				end else begin
					push_beat(KIND_NEGO, reply, b, 1'b0, 1'b0, 1'b1);
				end
				parse_len = 0;
			end
		end else begin
			if (esc_seen) begin
				if (b == BYTE_SE) begin
					// End of a suboption: the stored bytes from the option on are given,
					// but only for a known option.
					size = parse_len - 1;
					if (size >= 3 && size <= SUB_DEPTH + 1 && slot_lookup(cmd_store[2]) >= 0)
						for (int i = 2; i < size; i++)
							push_beat(KIND_SUB, cmd_store[i], 8'd0, 1'b0, 1'b0, i == size - 1);
					parse_len = 0;
				end else if (b != BYTE_IAC) begin
					// IAC followed by anything else drops both bytes; IAC IAC keeps one 255.
					parse_len = parse_len - 1;
				end
				esc_seen = 1'b0;
			end else begin
				// Once the store is full, the last slot is overwritten again and again.
				if (parse_len > SUB_DEPTH)
					parse_len = SUB_DEPTH;
				cmd_store[parse_len] = b;
				parse_len = parse_len + 1;
				if (b == BYTE_IAC)
					esc_seen = 1'b1;
			end
		end
		parse_len = parse_len & 8'h7F;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Every result beat taken by the receiver is matched against the oldest prediction.
	always @(posedge clk) begin : beat_checker
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with no prediction waiting: kind %0d value %0d", kind, value);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("value", want.value, value);
				check_field("option_number", want.option_number, option_number);
				check_field("remote_will", 8'(want.remote_will), 8'(remote_will));
				check_field("remote_do", 8'(want.remote_do), 8'(remote_do));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// Offers one byte and returns at the edge where it is accepted. Valid stays high
	// afterwards, so a caller that does not send again at once must lower it.
	task automatic send_byte(input logic [7:0] b);
		if (stall_enable && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		parse_rx_byte(b);
	endtask

	// Holds the sender off until every predicted beat has come, then lets the block settle.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four table registers on consecutive cycles, with noise in the unused bits.
	task automatic load_option_table(input logic [31:0] codes, input logic [3:0] valid_bits,
			input logic [3:0] will_bits, input logic [3:0] local_do_bits);
		logic [27:0] pad_a;
		logic [27:0] pad_b;
		logic [27:0] pad_c;
		pad_a = 28'($urandom());
		pad_b = 28'($urandom());
		pad_c = 28'($urandom());
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_OPTION_CODES;
		cfg_data  <= codes;
		@(posedge clk);
		cfg_index <= REG_OPTION_VALID;
		cfg_data  <= {pad_a, valid_bits};
		@(posedge clk);
		cfg_index <= REG_LOCAL_WILL;
		cfg_data  <= {pad_b, will_bits};
		@(posedge clk);
		cfg_index <= REG_LOCAL_DO;
		cfg_data  <= {pad_c, local_do_bits};
		@(posedge clk);
		cfg_we    <= 1'b0;
		tbl_codes = codes;
		tbl_valid = valid_bits;
		tbl_will  = will_bits;
		tbl_do    = local_do_bits;
	endtask

	// Mostly an option from the table, sometimes any byte at all.
	function automatic logic [7:0] pick_option();
		if ($urandom_range(0, 3) != 0)
			return tbl_codes[8*$urandom_range(0, 3) +: 8];
		return 8'($urandom_range(0, 255));
	endfunction

	// With the reset table every option is unknown.
	task automatic test_reset_table();
		send_byte(BYTE_IAC); send_byte(BYTE_WILL); send_byte(8'd0);
		send_byte(BYTE_IAC); send_byte(BYTE_SB); send_byte(8'd0);
		send_byte(BYTE_IAC); send_byte(BYTE_SE);
		wait_drain();
	endtask

	task automatic test_data_and_commands();
		send_byte(8'd0);
		send_byte(8'd254);
		send_byte(BYTE_IAC); send_byte(BYTE_IAC);
		send_byte(BYTE_IAC); send_byte(8'd0);
		send_byte(BYTE_IAC); send_byte(8'd249);
	endtask

	// Table here: slot 0 = 1, slot 1 = 24, slot 2 = 31, slot 3 = 255.
	task automatic test_negotiation();
		send_byte(BYTE_IAC); send_byte(BYTE_WILL); send_byte(8'd1);
		send_byte(BYTE_IAC); send_byte(BYTE_DO);   send_byte(8'd24);
		send_byte(BYTE_IAC); send_byte(BYTE_WONT); send_byte(8'd1);
		send_byte(BYTE_IAC); send_byte(BYTE_DONT); send_byte(8'd24);
		send_byte(BYTE_IAC); send_byte(BYTE_WILL); send_byte(8'd200);
		send_byte(BYTE_IAC); send_byte(BYTE_DO);   send_byte(8'd255);
	endtask

	task automatic test_suboptions();
		// Escaped IAC kept, IAC with another byte dropped.
		send_byte(BYTE_IAC); send_byte(BYTE_SB); send_byte(8'd1);
		send_byte(BYTE_IAC); send_byte(BYTE_IAC); send_byte(8'd17);
		send_byte(BYTE_IAC); send_byte(8'd7);
		send_byte(BYTE_IAC); send_byte(BYTE_SE);
		// Unknown option: nothing comes out.
		send_byte(BYTE_IAC); send_byte(BYTE_SB); send_byte(8'd99); send_byte(8'd5);
		send_byte(BYTE_IAC); send_byte(BYTE_SE);
		// A body longer than the store overwrites the last slot.
		send_byte(BYTE_IAC); send_byte(BYTE_SB); send_byte(8'd24);
		for (int i = 0; i < SUB_DEPTH + 2; i++)
			send_byte(8'($urandom_range(0, 254)));
		send_byte(BYTE_IAC); send_byte(BYTE_SE);
		wait_drain();
	endtask

	// Random traffic: mostly well-formed commands with random content, plus noise
	// and suboptions left open. When drain_midway is set, a drain halfway through holds the sender off once.
	task automatic test_random_traffic(input int n_items, input bit drain_midway);
		int         sent;
		int         body_len;
		int         pick;
		logic [7:0] esc;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_byte(8'($urandom_range(0, 254)));
				sent += 1;
			end else if (pick < 42) begin
				send_byte(BYTE_IAC); send_byte(BYTE_IAC);
				sent += 2;
			end else if (pick < 52) begin
				send_byte(BYTE_IAC); send_byte(8'($urandom_range(0, 249)));
				sent += 2;
			end else if (pick < 75) begin
				send_byte(BYTE_IAC); send_byte(8'($urandom_range(BYTE_WILL, BYTE_DONT)));
				send_byte(pick_option());
				sent += 3;
			end else if (pick < 93) begin
				send_byte(BYTE_IAC); send_byte(BYTE_SB); send_byte(pick_option());
				sent += 3;
				body_len = ($urandom_range(0, 11) == 0) ? $urandom_range(26, 40)
					: $urandom_range(0, 6);
				for (int i = 0; i < body_len; i++) begin
					case ($urandom_range(0, 9))
						0: begin
							send_byte(BYTE_IAC); send_byte(BYTE_IAC);
							sent += 2;
						end
						1: begin
							esc = 8'($urandom_range(0, 254));
							if (esc == BYTE_SE)
								esc = 8'd241;
							send_byte(BYTE_IAC); send_byte(esc);
							sent += 2;
						end
						default: begin
							send_byte(8'($urandom_range(0, 254)));
							sent += 1;
						end
					endcase
				end
				// Now and then the suboption is left open and swallows what follows.
				if ($urandom_range(0, 9) != 0) begin
					send_byte(BYTE_IAC); send_byte(BYTE_SE);
					sent += 2;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					send_byte(8'($urandom_range(0, 255)));
					sent += 1;
				end
			end
			if (drain_midway && sent >= n_items / 2) begin
				wait_drain();
				drain_midway = 1'b0;
			end
		end
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i <= SUB_DEPTH; i++)
			cmd_store[i] = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_table();
		load_option_table({8'd255, 8'd31, 8'd24, 8'd1}, 4'b1111, 4'b0101, 4'b0011);
		test_data_and_commands();
		test_negotiation();
		test_suboptions();

		load_option_table($urandom(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)));
		test_random_traffic(68, 1'b1);
		load_option_table(32'hFFFF_FFFF, 4'hF, 4'hF, 4'hF);
		test_random_traffic(68, 1'b0);
		begin : dup_codes
			logic [7:0] code;
			code = 8'($urandom_range(0, 255));
			load_option_table({4{code}}, 4'b1110, 4'b1010, 4'b0110);
		end
		test_random_traffic(68, 1'b0);

		// The last part runs with no idling on either side.
		stall_enable = 1'b0;
		load_option_table($urandom(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)));
		test_random_traffic(68, 1'b0);
		load_option_table(32'd0, 4'd0, 4'd0, 4'd0);
		test_random_traffic(12, 1'b0);

		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("testbench OK");
		end else begin
			if (expected_beats.size() != 0)
				$error("%0d predicted beats never arrived", expected_beats.size());
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/tcsp_pkg.sv
hdl/tcsp_ram.sv
hdl/tcsp_ctrl.sv
hdl/tcsp_datapath.sv
hdl/telnet_command_stream_parser_unit.sv
hdl/tcsp_checker.sv
dv/testbench.sv
